>>> design/operation_table_canonical_check_macros.svh
// assertion helpers included by operation_table_canonical_check.sv
`ifndef OPERATION_TABLE_CANONICAL_CHECK_MACROS_SVH
`define OPERATION_TABLE_CANONICAL_CHECK_MACROS_SVH

// checked only while out of reset
`define OTCC_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define OTCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

>>> design/otcc_pkg.sv
`default_nettype none
package otcc_pkg;

    localparam int CODE_W = 15;
    localparam int ORDER_W = 2;
    localparam int NCELL3 = 9;
    localparam int NCELL2 = 4;
    localparam int NPERM3 = 5;
    localparam int TRITS_PER_STAGE = 3;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [ORDER_W-1:0] order_t;
    typedef logic [1:0]         trit_t;
    typedef trit_t [NCELL3-1:0] trits_t;
    typedef trit_t [2:0]        perm_t;

    localparam order_t ORDER_TWO   = 2'd2;
    localparam order_t ORDER_RESET = 2'd3;

    localparam code_t LIMIT2 = 15'd16;
    localparam code_t LIMIT3 = 15'd19683;

    // weight of each base-3 digit position
    localparam code_t WEIGHT3 [NCELL3] = '{
        15'd1, 15'd3, 15'd9, 15'd27, 15'd81, 15'd243, 15'd729, 15'd2187, 15'd6561
    };

    // non-identity relabellings of three elements, packed as {p(2), p(1), p(0)}
    localparam perm_t PERM3 [NPERM3] = '{
        {2'd1, 2'd2, 2'd0},
        {2'd2, 2'd0, 2'd1},
        {2'd0, 2'd2, 2'd1},
        {2'd1, 2'd0, 2'd2},
        {2'd0, 2'd1, 2'd2}
    };

    typedef struct packed {
        code_t           rem;
        trits_t          trits;
        logic [NCELL2-1:0] bits;
        logic            n2;
        logic            oor;
    } stage_t;

    typedef struct packed {
        logic [NPERM3-1:0] perm3_less;
        logic              swap2_less;
    } cmp_flags_t;

    typedef struct packed {
        trit_t trit;
        code_t rem;
    } split_t;

    // peel one base-3 digit of weight w off the remainder
    function automatic split_t trit_split(input code_t rem, input code_t w);
        split_t sp;
        code_t  w2;
        w2 = code_t'({w, 1'b0});
        if (rem >= w2) begin
            sp.trit = 2'd2;
            sp.rem  = rem - w2;
        end else if (rem >= w) begin
            sp.trit = 2'd1;
            sp.rem  = rem - w;
        end else begin
            sp.trit = 2'd0;
            sp.rem  = rem;
        end
        return sp;
    endfunction

endpackage
`default_nettype wire

>>> design/otcc_img_cmp.sv
`default_nettype none
module otcc_img_cmp
    import otcc_pkg::*;
(
    input  wire trits_t            trits,
    input  wire logic [NCELL2-1:0] bits,
    output cmp_flags_t             flags
);

    // relabel the digit table under each permutation and compare digit-wise
    // from the most significant cell down
    always_comb begin
        trits_t            img;
        perm_t             p;
        logic              less;
        logic              decided;
        logic [NCELL2-1:0] img2;
        flags = '0;
        for (int k = 0; k < NPERM3; k++) begin
            p = PERM3[k];
            img = '0;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    img[4'(3 * p[r] + p[c])] = p[trits[3 * r + c]];
                end
            end
            less = 1'b0;
            decided = 1'b0;
            for (int i = NCELL3 - 1; i >= 0; i--) begin
                if (!decided && img[i] != trits[i]) begin
                    less = img[i] < trits[i];
                    decided = 1'b1;
                end
            end
            flags.perm3_less[k] = less;
        end
        // two elements: swap moves cell i to cell 3-i and inverts its value
        for (int i = 0; i < NCELL2; i++) begin
            img2[NCELL2 - 1 - i] = ~bits[i];
        end
        flags.swap2_less = img2 < bits;
    end

endmodule
`default_nettype wire

>>> design/operation_table_canonical_check.sv
// pipeline: 5 register stages, st1_reg to st4_reg and the output register
// throughput: one table per cycle when m_tready does not stall the output; the three
//   digit-extraction stages, three base-3 digits each, set the pipeline depth
// reset: aresetn synchronous active low; clears all stage valid bits and loads
//   table_order with 3; cfg_ready is always high
`default_nettype none
module operation_table_canonical_check
    import otcc_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // config write channel, table_order in cfg_data
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire order_t       cfg_data,
    // input stream
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [15:0]  s_tdata,   // [14:0] table_code, [15] zero
    // result stream
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata    // [0] is_canonical, [1] out_of_range, [7:2] zero
);

    // ---------------------------------------------------------------- config
    order_t table_order_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_order_reg <= ORDER_RESET;
        end else if (cfg_valid && cfg_ready) begin
            table_order_reg <= cfg_data;
        end
    end

    // ---------------------------------------------------------------- flow control
    // each stage loads when its successor is empty or also moving, so bubbles
    // are squeezed out while a result waits
    logic   vld1_reg, vld2_reg, vld3_reg, vld4_reg, out_vld_reg;
    logic   ld1, ld2, ld3, ld4, ld_out;
    stage_t st1_reg, st2_reg, st3_reg, st4_reg;
    stage_t st1_next, st2_next, st3_next, st4_next;
    logic   canon_reg, oor_reg;
    logic   canon_next;
    cmp_flags_t flags;

    assign ld_out   = !out_vld_reg || m_tready;
    assign ld4      = !vld4_reg || ld_out;
    assign ld3      = !vld3_reg || ld4;
    assign ld2      = !vld2_reg || ld3;
    assign ld1      = !vld1_reg || ld2;
    assign s_tready = ld1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg    <= 1'b0;
            vld2_reg    <= 1'b0;
            vld3_reg    <= 1'b0;
            vld4_reg    <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (ld1)    vld1_reg    <= s_tvalid;
            if (ld2)    vld2_reg    <= vld1_reg;
            if (ld3)    vld3_reg    <= vld2_reg;
            if (ld4)    vld4_reg    <= vld3_reg;
            if (ld_out) out_vld_reg <= vld4_reg;
        end
    end

    // ---------------------------------------------------------------- stage 1
    // capture the code, pick the order and flag codes past the table range
    always_comb begin
        code_t code;
        logic  n2;
        code = s_tdata[CODE_W-1:0];
        n2 = (table_order_reg == ORDER_TWO);
        st1_next.rem   = code;
        st1_next.trits = '0;
        st1_next.bits  = code[NCELL2-1:0];
        st1_next.n2    = n2;
        st1_next.oor   = n2 ? (code >= LIMIT2) : (code >= LIMIT3);
    end

    // ---------------------------------------------------------------- stages 2-4
    // three base-3 digits per stage, most significant first
    always_comb begin
        split_t sp;
        st2_next = st1_reg;
        for (int m = 0; m < TRITS_PER_STAGE; m++) begin
            sp = trit_split(st2_next.rem, WEIGHT3[NCELL3 - 1 - m]);
            st2_next.trits[NCELL3 - 1 - m] = sp.trit;
            st2_next.rem = sp.rem;
        end
    end

    always_comb begin
        split_t sp;
        st3_next = st2_reg;
        for (int m = 0; m < TRITS_PER_STAGE; m++) begin
            sp = trit_split(st3_next.rem, WEIGHT3[NCELL3 - 1 - TRITS_PER_STAGE - m]);
            st3_next.trits[NCELL3 - 1 - TRITS_PER_STAGE - m] = sp.trit;
            st3_next.rem = sp.rem;
        end
    end

    always_comb begin
        split_t sp;
        st4_next = st3_reg;
        for (int m = 0; m < TRITS_PER_STAGE; m++) begin
            sp = trit_split(st4_next.rem, WEIGHT3[NCELL3 - 1 - 2 * TRITS_PER_STAGE - m]);
            st4_next.trits[NCELL3 - 1 - 2 * TRITS_PER_STAGE - m] = sp.trit;
            st4_next.rem = sp.rem;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (ld1) st1_reg <= st1_next;
        if (ld2) st2_reg <= st2_next;
        if (ld3) st3_reg <= st3_next;
        if (ld4) st4_reg <= st4_next;
    end

    // ---------------------------------------------------------------- stage 5
    // relabel and compare against every non-identity permutation at once
    otcc_img_cmp u_img_cmp (
        .trits (st4_reg.trits),
        .bits  (st4_reg.bits),
        .flags (flags)
    );

    // an out-of-range code is never canonical
    assign canon_next = !st4_reg.oor
                      && !(st4_reg.n2 ? flags.swap2_less : (|flags.perm3_less));

    always_ff @(posedge aclk) begin
        if (ld_out) begin
            canon_reg <= canon_next;
            oor_reg   <= st4_reg.oor;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {6'd0, oor_reg, canon_reg};

    // ---------------------------------------------------------------- checks
`include "operation_table_canonical_check_macros.svh"

    `OTCC_ASSERT_ALWAYS(a_ord_rst, !aresetn |=> table_order_reg == ORDER_RESET, "order not reset")
    `OTCC_ASSERT_RUN(a_oor_canon, m_tvalid && m_tdata[1] |-> !m_tdata[0], "oor marked canonical")
    `OTCC_ASSERT_RUN(a_rdy_empty, !m_tvalid && !vld4_reg |-> s_tready, "input blocked")
    `OTCC_ASSERT_RUN(a_st4_hold, !ld4 |=> $stable({vld4_reg, st4_reg}), "stage 4 moved in stall")

endmodule
`default_nettype wire
